/* src/rfdm_pkg.sv */
// ----------------------------------------------------------------------------
// rfdm_pkg
// shared types, constants and helpers of the remote frame decode mixer
// ----------------------------------------------------------------------------
package rfdm_pkg;

  localparam int unsigned STORE_BYTES = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CH_W        = 11;
  localparam int unsigned CTR_W       = 12;
  localparam int unsigned ORDER_W     = 16;
  localparam int unsigned LIMIT_W     = 10;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned SW_W        = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [CTR_W-1:0]   CH_OFFSET        = 12'd1024;
  localparam logic [LIMIT_W-1:0] STICK_LIMIT_RST  = 10'd660;
  localparam logic [LIMIT_W-1:0] DEADBAND_RST     = 10'd5;
  localparam logic [GAIN_W-1:0]  MOUSE_GAIN_RST   = 8'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_LIMIT = 2'd0,
    CFG_DEADBAND    = 2'd1,
    CFG_MOUSE_GAIN  = 2'd2
  } cfg_idx_t;

  localparam logic [SW_W-1:0] MODE_DRIVE = 2'd1;
  localparam logic [SW_W-1:0] MODE_LIFT  = 2'd2;

  typedef logic [STORE_BYTES-1:0][BYTE_W-1:0] frame_t;

  typedef struct packed {
    logic                  bad;
    logic [SW_W-1:0]       sw_l;
    logic [SW_W-1:0]       sw_r;
    logic [BYTE_W-1:0]     m_l;
    logic [BYTE_W-1:0]     m_r;
    logic [ORDER_W-1:0]    keys;
    logic [ORDER_W-1:0]    fb;
    logic [ORDER_W-1:0]    lr;
    logic [ORDER_W-1:0]    rot_base;
    logic [ORDER_W-1:0]    rot_add;
    logic [ORDER_W-1:0]    ud;
  } unpack_t;

  function automatic logic [ORDER_W-1:0] deadband(input logic [ORDER_W-1:0] x,
                                                  input logic [LIMIT_W-1:0] d);
    logic signed [ORDER_W:0] xs;
    logic signed [ORDER_W:0] ds;
    xs = $signed({x[ORDER_W-1], x});
    ds = $signed({{(ORDER_W+1-LIMIT_W){1'b0}}, d});
    if ((xs < ds) && (xs > -ds)) begin
      return '0;
    end
    return x;
  endfunction

endpackage

/* src/remote_frame_decode_mixer.sv */
// ----------------------------------------------------------------------------
// remote_frame_decode_mixer
// decodes remote-control frames from a byte stream into motion orders
//
//   channel | direction | beat
//   in_     | input     | one frame byte
//   out_    | output    | one decoded frame: orders, switches, mouse, keys
//   cfg_    | input     | register index and write data
//
// one byte per cycle while in_ready is high; a 16-cell shift chain collects frame bytes 0..15
// the result passes the unpack and finish registers after the last byte of a frame
// sync reset clears position, held vertical order and valids, and restores the config registers to their defaults
// out_ready low holds the result; one more frame waits in the unpack stage
// in_ready drops only while both stages hold a frame
// ----------------------------------------------------------------------------
module remote_frame_decode_mixer
  import rfdm_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ORDER_W-1:0]    out_forward_back,
  output logic [ORDER_W-1:0]    out_left_right,
  output logic [ORDER_W-1:0]    out_rotation,
  output logic [ORDER_W-1:0]    out_up_down,
  output logic [SW_W-1:0]       out_left_switch,
  output logic [SW_W-1:0]       out_right_switch,
  output logic [BYTE_W-1:0]     out_mouse_left,
  output logic [BYTE_W-1:0]     out_mouse_right,
  output logic [ORDER_W-1:0]    out_keyboard_keys,
  output logic                  out_frame_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W:0]   POS_STORE = (POS_W+1)'(STORE_BYTES);

  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [LIMIT_W-1:0] stick_limit_r, stick_limit_nxt;
  logic [LIMIT_W-1:0] deadband_r, deadband_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic               in_acc;
  logic               last;
  logic               shift;
  frame_t             cell_q;
  frame_t             cell_ahead;
  logic               s1_valid;
  unpack_t            s1;
  logic               take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !s1_valid || take;
  assign in_acc    = in_valid && in_ready;
  assign last      = (pos_r == POS_LAST);
  assign shift     = in_acc && ({1'b0, pos_r} < POS_STORE);
  assign pos_nxt   = in_acc ? (last ? '0 : POS_W'(pos_r + 1'b1)) : pos_r;

  always_comb begin
    stick_limit_nxt = stick_limit_r;
    deadband_nxt    = deadband_r;
    gain_nxt        = gain_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STICK_LIMIT: stick_limit_nxt = cfg_data[LIMIT_W-1:0];
        CFG_DEADBAND:    deadband_nxt    = cfg_data[LIMIT_W-1:0];
        CFG_MOUSE_GAIN:  gain_nxt        = cfg_data[GAIN_W-1:0];
        default: begin
          gain_nxt = gain_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      stick_limit_r <= STICK_LIMIT_RST;
      deadband_r    <= DEADBAND_RST;
      gain_r        <= MOUSE_GAIN_RST;
    end else begin
      pos_r         <= pos_nxt;
      stick_limit_r <= stick_limit_nxt;
      deadband_r    <= deadband_nxt;
      gain_r        <= gain_nxt;
    end
  end

  for (genvar k = 0; k < STORE_BYTES; k++) begin : g_cell
    logic [BYTE_W-1:0] feed;
    if (k == STORE_BYTES - 1) begin : g_head
      assign feed = in_rx_byte;
    end else begin : g_body
      assign feed = cell_q[k+1];
    end
    rfdm_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .byte_in    (feed),
      .byte_q     (cell_q[k]),
      .byte_ahead (cell_ahead[k])
    );
  end

  rfdm_unpack u_unpack (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_acc && last),
    .take        (take),
    .frame       (cell_ahead),
    .stick_limit (stick_limit_r),
    .gain        (gain_r),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  rfdm_finish u_finish (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid),
    .s1                (s1),
    .deadband_limit    (deadband_r),
    .take              (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_forward_back  (out_forward_back),
    .out_left_right    (out_left_right),
    .out_rotation      (out_rotation),
    .out_up_down       (out_up_down),
    .out_left_switch   (out_left_switch),
    .out_right_switch  (out_right_switch),
    .out_mouse_left    (out_mouse_left),
    .out_mouse_right   (out_mouse_right),
    .out_keyboard_keys (out_keyboard_keys),
    .out_frame_error   (out_frame_error)
  );

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_error) |-> (out_forward_back == '0 && out_left_right == '0 &&
      out_rotation == '0 && out_left_switch == '0 && out_keyboard_keys == '0))
    else $error("bad frame result carries motion or switch data");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without two pending frames");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position beyond frame length");

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last) |=> (pos_r == '0 && s1_valid))
    else $error("last byte did not restart frame and load unpack stage");

endmodule

/* src/rfdm_cell.sv */
// ----------------------------------------------------------------------------
// rfdm_cell
// one byte cell of the frame shift chain, with look-ahead of its next value
// ----------------------------------------------------------------------------
module rfdm_cell
  import rfdm_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [BYTE_W-1:0] byte_q,
  output logic [BYTE_W-1:0] byte_ahead
);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  assign byte_nxt   = shift ? byte_in : byte_r;
  assign byte_q     = byte_r;
  assign byte_ahead = byte_nxt;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

/* src/rfdm_unpack.sv */
// ----------------------------------------------------------------------------
// rfdm_unpack
// unpacks sticks, switches, mouse and keys, checks the limit and selects the mode
// ----------------------------------------------------------------------------
module rfdm_unpack
  import rfdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic               take,
  input  frame_t             frame,
  input  logic [LIMIT_W-1:0] stick_limit,
  input  logic [GAIN_W-1:0]  gain,
  output logic               s1_valid,
  output unpack_t            s1
);

  logic                      valid_r;
  logic                      valid_nxt;
  unpack_t                   s1_r;
  unpack_t                   s1_nxt;
  logic [6*BYTE_W-1:0]       bits;
  logic [3:0][CH_W-1:0]      raw;
  logic [3:0][CTR_W-1:0]     ctr;
  logic [3:0][CH_W-1:0]      mag;
  logic [3:0]                over;
  logic [ORDER_W-1:0]        mouse_x;
  logic [ORDER_W+GAIN_W-1:0] prod;
  logic [SW_W-1:0]           sw_l;

  assign bits = {frame[5], frame[4], frame[3], frame[2], frame[1], frame[0]};
  assign raw[0] = bits[10:0];
  assign raw[1] = bits[21:11];
  assign raw[2] = bits[32:22];
  assign raw[3] = bits[43:33];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ctr[i]  = {1'b0, raw[i]} - CH_OFFSET;
      mag[i]  = ctr[i][CTR_W-1] ? CH_W'(-ctr[i]) : ctr[i][CH_W-1:0];
      over[i] = mag[i] > {1'b0, stick_limit};
    end
  end

  assign mouse_x = {frame[7], frame[6]};
  assign prod    = {{GAIN_W{1'b0}}, mouse_x} * {{ORDER_W{1'b0}}, gain};
  assign sw_l    = frame[5][7:6];

  always_comb begin
    s1_nxt = '0;
    if (|over) begin
      s1_nxt.bad = 1'b1;
    end else begin
      s1_nxt.sw_l = sw_l;
      s1_nxt.sw_r = frame[5][5:4];
      s1_nxt.m_l  = frame[12];
      s1_nxt.m_r  = frame[13];
      s1_nxt.keys = {frame[15], frame[14]};
      unique case (sw_l)
        MODE_DRIVE: begin
          s1_nxt.fb       = {{(ORDER_W-CTR_W){ctr[1][CTR_W-1]}}, ctr[1]};
          s1_nxt.lr       = {{(ORDER_W-CTR_W){ctr[0][CTR_W-1]}}, ctr[0]};
          s1_nxt.rot_base = {{(ORDER_W-CTR_W){ctr[2][CTR_W-1]}}, ctr[2]};
          s1_nxt.rot_add  = prod[ORDER_W-1:0];
        end
        MODE_LIFT: begin
          s1_nxt.ud = {{(ORDER_W-CTR_W){ctr[1][CTR_W-1]}}, ctr[1]};
        end
        default: begin
          s1_nxt.ud = '0;
        end
      endcase
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = s1_r;

endmodule

/* src/rfdm_finish.sv */
// ----------------------------------------------------------------------------
// rfdm_finish
// adds mouse rotation, applies the deadband and holds the result beat
// ----------------------------------------------------------------------------
module rfdm_finish
  import rfdm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  unpack_t            s1,
  input  logic [LIMIT_W-1:0] deadband_limit,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ORDER_W-1:0] out_forward_back,
  output logic [ORDER_W-1:0] out_left_right,
  output logic [ORDER_W-1:0] out_rotation,
  output logic [ORDER_W-1:0] out_up_down,
  output logic [SW_W-1:0]    out_left_switch,
  output logic [SW_W-1:0]    out_right_switch,
  output logic [BYTE_W-1:0]  out_mouse_left,
  output logic [BYTE_W-1:0]  out_mouse_right,
  output logic [ORDER_W-1:0] out_keyboard_keys,
  output logic               out_frame_error
);

  logic               valid_r;
  logic               valid_nxt;
  logic               load;
  logic [ORDER_W-1:0] held_r;
  logic [ORDER_W-1:0] held_nxt;
  logic [ORDER_W-1:0] rot_sum;
  logic [ORDER_W-1:0] ud_pre;
  logic [ORDER_W-1:0] fb_r, lr_r, rot_r, ud_r, keys_r;
  logic [SW_W-1:0]    sw_l_r, sw_r_r;
  logic [BYTE_W-1:0]  m_l_r, m_r_r;
  logic               err_r;

  assign take     = !valid_r || out_ready;
  assign load     = s1_valid && take;
  assign rot_sum  = s1.rot_base + s1.rot_add;
  assign ud_pre   = s1.bad ? held_r : s1.ud;
  assign held_nxt = load ? deadband(ud_pre, deadband_limit) : held_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      held_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      held_r  <= held_nxt;
    end
    if (load) begin
      fb_r   <= deadband(s1.fb, deadband_limit);
      lr_r   <= deadband(s1.lr, deadband_limit);
      rot_r  <= deadband(rot_sum, deadband_limit);
      ud_r   <= held_nxt;
      sw_l_r <= s1.sw_l;
      sw_r_r <= s1.sw_r;
      m_l_r  <= s1.m_l;
      m_r_r  <= s1.m_r;
      keys_r <= s1.keys;
      err_r  <= s1.bad;
    end
  end

  assign out_valid         = valid_r;
  assign out_forward_back  = fb_r;
  assign out_left_right    = lr_r;
  assign out_rotation      = rot_r;
  assign out_up_down       = ud_r;
  assign out_left_switch   = sw_l_r;
  assign out_right_switch  = sw_r_r;
  assign out_mouse_left    = m_l_r;
  assign out_mouse_right   = m_r_r;
  assign out_keyboard_keys = keys_r;
  assign out_frame_error   = err_r;

endmodule
